// ===== src/bitmap_block_allocator_macros.svh =====
// Assertion macros for the bitmap block allocator.
// Used by bitmap_block_allocator.sv; relies on clk and rst_n in the including scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every rising clock edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising clock edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/bba_pkg.sv =====
// Types and constants shared by the bitmap block allocator.
// No dependencies; imported by bitmap_block_allocator.sv.
package bba_pkg;

  localparam int BLK_W          = 12;
  localparam int CNT_W          = 13;
  localparam int INDEX_SPACE    = 4096;
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int MAP_WORD_MAX   = 64;
  localparam int TOTAL_RST      = 4096;
  localparam int RESERVED_RST   = 10;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_RANGE     = 3'd2,
    ST_RESERVED  = 3'd3,
    ST_NO_FREE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_ENABLED  = 2'd0,
    CFG_TOTAL    = 2'd1,
    CFG_RESERVED = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic [BLK_W-1:0]   block_index;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [BLK_W-1:0]   granted_block;
    logic               is_used;
    logic [CNT_W-1:0]   free_count;
  } out_word_t;

endpackage

// ===== src/bitmap_block_allocator.sv =====
// First-fit bitmap block allocator, top level.
// Depends on bba_pkg and bitmap_block_allocator_macros.svh.
//
// Usage: in_data carries one request word (allocate, free or query) and is
// taken at an edge with in_valid high and in_stall low. Each request gives
// exactly one result word on out_data, taken with out_valid high and
// out_stall low. Configuration words (enable, total blocks, reserved blocks)
// arrive on the cfg_ channel, which is always ready.
// The used map lives in a memory of 64-bit words, one read and one write
// port, read data registered. A free or query that passes its checks reads
// one word, then goes through the read-modify-write and hold states. Allocate
// scans words from the one holding the first unreserved block, one word per
// cycle, up to 64 words at 4096 blocks.
// One request is in work at a time; the next is accepted once the result is
// placed in the output register, even if the receiver still stalls it.
// A stalled result holds in the output register; a finished request then
// waits in a holding stage until the register frees.
// After reset a clearing pass writes zero to every map word, one word a
// cycle, and no request is accepted meanwhile.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CNT_W-1:0]    cfg_data
);

`include "bitmap_block_allocator_macros.svh"

  // Map geometry: only blocks below the index space are ever touched.
  localparam int LIVE_BLOCKS = (MAX_BLOCKS < INDEX_SPACE) ? MAX_BLOCKS : INDEX_SPACE;
  localparam int WORD_W = (LIVE_BLOCKS < MAP_WORD_MAX) ? (2 ** $clog2(LIVE_BLOCKS))
                                                       : MAP_WORD_MAX;
  localparam int BW    = $clog2(WORD_W);
  localparam int WORDS = (LIVE_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_SCAN = 5'b00100,
    S_RMW  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  // Map memory.
  logic [WORD_W-1:0] map_mem [WORDS];
  logic [WORD_W-1:0] mem_q_r;
  logic              mem_re;
  logic [WA-1:0]     mem_ra;
  logic              mem_we;
  logic [WA-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;

  // Control and configuration registers.
  state_t            state_r, state_nxt;
  logic [WA-1:0]     clr_r, clr_nxt;
  logic [WA-1:0]     chk_w_r, chk_w_nxt;
  in_word_t          req_r, req_nxt;
  out_word_t         res_r, res_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              enabled_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  reserved_r;

  // Derived configuration values.
  logic [CNT_W-1:0]  eff_total;
  logic [BLK_W-1:0]  last_blk;
  logic [WA-1:0]     start_w;
  logic [WA-1:0]     last_w;
  logic [BW-1:0]     start_bit;
  logic [BW-1:0]     last_bit;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  span;

  // Scan datapath.
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] cand;
  logic [WORD_W-1:0] low_one;
  logic [BW-1:0]     low_pos;
  logic              found;
  logic [BW-1:0]     req_bit;
  logic              req_used;
  logic              in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Effective total and scan bounds.
  always_comb begin
    eff_total = (total_r > CNT_W'(LIVE_BLOCKS)) ? CNT_W'(LIVE_BLOCKS) : total_r;
    last_blk  = BLK_W'(eff_total - CNT_W'(1));
    start_w   = WA'(reserved_r[BLK_W-1:0] >> BW);
    last_w    = WA'(last_blk >> BW);
    start_bit = reserved_r[BW-1:0];
    last_bit  = last_blk[BW-1:0];
  end

  // Free count, saturating at zero.
  always_comb begin
    span       = eff_total - reserved_r;
    free_count = '0;
    if ((eff_total > reserved_r) && (span > count_r)) begin
      free_count = span - count_r;
    end
  end

  // Lowest free, in-range bit of the word under scan.
  always_comb begin
    lo_mask = (chk_w_r == start_w) ? ({WORD_W{1'b1}} << start_bit) : {WORD_W{1'b1}};
    hi_mask = (chk_w_r == last_w)
              ? ({WORD_W{1'b1}} >> (BW'(WORD_W - 1) - last_bit)) : {WORD_W{1'b1}};
    cand    = ~mem_q_r & lo_mask & hi_mask;
    low_one = cand & (~cand + WORD_W'(1));
    found   = |cand;
    low_pos = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (low_one[j]) begin
        low_pos = low_pos | BW'(j);
      end
    end
  end

  assign req_bit  = req_r.block_index[BW-1:0];
  assign req_used = mem_q_r[req_bit];

  // Sequencer: next state, memory access and result build.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    chk_w_nxt     = chk_w_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    count_nxt     = count_r;
    mem_re        = 1'b0;
    mem_ra        = chk_w_r;
    mem_we        = 1'b0;
    mem_wa        = chk_w_r;
    mem_wd        = mem_q_r;

    // The output register empties when its word is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + WA'(1);
        if (clr_r == WA'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          state_nxt = S_HOLD;
          unique case (in_data.kind)
            KIND_ALLOC: begin
              if (!enabled_r) begin
                res_nxt.status = ST_DISABLED;
              end else if (reserved_r >= eff_total) begin
                res_nxt.status = ST_NO_FREE;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = start_w;
                chk_w_nxt = start_w;
                state_nxt = S_SCAN;
              end
            end
            KIND_FREE: begin
              if (!enabled_r) begin
                res_nxt.status = ST_DISABLED;
              end else if (CNT_W'(in_data.block_index) >= eff_total) begin
                res_nxt.status = ST_RANGE;
              end else if (CNT_W'(in_data.block_index) < reserved_r) begin
                res_nxt.status = ST_RESERVED;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = WA'(in_data.block_index >> BW);
                state_nxt = S_RMW;
              end
            end
            KIND_QUERY: begin
              if (CNT_W'(in_data.block_index) >= eff_total) begin
                res_nxt.is_used = 1'b0;
              end else if (CNT_W'(in_data.block_index) < reserved_r) begin
                res_nxt.is_used = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = WA'(in_data.block_index >> BW);
                state_nxt = S_RMW;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (found) begin
          mem_we    = 1'b1;
          mem_wa    = chk_w_r;
          mem_wd    = mem_q_r | low_one;
          count_nxt = count_r + CNT_W'(1);
          res_nxt.status        = ST_OK;
          res_nxt.granted_block = (BLK_W'(chk_w_r) << BW) | BLK_W'(low_pos);
          state_nxt = S_HOLD;
        end else if (chk_w_r == last_w) begin
          res_nxt.status = ST_NO_FREE;
          state_nxt      = S_HOLD;
        end else begin
          // Fetch the next word while this one is checked.
          mem_re    = 1'b1;
          mem_ra    = chk_w_r + WA'(1);
          chk_w_nxt = chk_w_r + WA'(1);
        end
      end

      S_RMW: begin
        if (req_r.kind == KIND_FREE) begin
          if (req_used) begin
            mem_we = 1'b1;
            mem_wa = WA'(req_r.block_index >> BW);
            mem_wd = mem_q_r & ~(WORD_W'(1) << req_bit);
            if (count_r != '0) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end else begin
          res_nxt.is_used = req_used;
        end
        state_nxt = S_HOLD;
      end

      S_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt            = res_r;
          out_nxt.free_count = free_count;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // Map memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= map_mem[mem_ra];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_w_r <= chk_w_nxt;
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      total_r    <= CNT_W'(TOTAL_RST);
      reserved_r <= CNT_W'(RESERVED_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLED:  enabled_r  <= cfg_data[0];
        CFG_TOTAL:    total_r    <= cfg_data;
        CFG_RESERVED: reserved_r <= cfg_data;
        default:      enabled_r  <= enabled_r;
      endcase
    end
  end

  // Assertions.
  `BBA_ASSERT(a_count_bound, count_r <= CNT_W'(LIVE_BLOCKS), "allocated count past map size")
  `BBA_ASSERT(a_idle_no_write, (state_r == S_IDLE) |-> !mem_we, "map written while idle")
  `BBA_ASSERT(a_out_from_hold, $rose(out_valid_r) |-> $past(state_r == S_HOLD), "result without hold")
  `BBA_ASSERT(a_grant_unreserved,
              (out_valid_r && (out_r.status == ST_OK) && (out_r.granted_block != '0))
              |-> (CNT_W'(out_r.granted_block) >= reserved_r), "granted block is reserved")

endmodule

// ===== tb/sv/bitmap_block_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap block allocator: directed and random request words,
// predicted in the bench from its own copy of the used map and register settings.
// Depends on bba_pkg and bitmap_block_allocator.
module bitmap_block_allocator_test;
  import bba_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 80;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [CNT_W-1:0] cfg_data  = '0;

  // Bench copy of the allocator state and its registers.
  bit               used_blocks [INDEX_SPACE];
  logic [CNT_W-1:0] used_total  = '0;
  bit               mounted     = 1'b0;
  logic [CNT_W-1:0] dev_blocks  = CNT_W'(TOTAL_RST);
  logic [CNT_W-1:0] meta_blocks = CNT_W'(RESERVED_RST);

  // Result words still owed by the block, oldest first, and blocks handed out so far.
  out_word_t        awaited_words [$];
  logic [BLK_W-1:0] granted_list [$];

  // Sender and receiver pacing.
  int          gap_max    = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          hold_token = 0;

  // Run statistics.
  int error_count   = 0;
  int checked_count = 0;
  int grant_count   = 0;
  int full_count    = 0;
  int off_count     = 0;
  int kind_tally [4];
  int cycle_count   = 0;

  bitmap_block_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Block count actually usable: the total register clipped to the map and the index space.
  function automatic int usable_limit();
    int t;
    t = int'(dev_blocks);
    if (t > MAX_BLOCKS_DEF) t = MAX_BLOCKS_DEF;
    if (t > INDEX_SPACE) t = INDEX_SPACE;
    return t;
  endfunction

  // Free non-reserved blocks, saturating at zero when the settings shrink below the map.
  function automatic logic [CNT_W-1:0] spare_blocks();
    int               t;
    logic [CNT_W-1:0] n;
    t = usable_limit();
    if (t <= int'(meta_blocks)) return '0;
    t = t - int'(meta_blocks);
    if (t <= int'(used_total)) return '0;
    n = CNT_W'(t - int'(used_total));
    return n;
  endfunction

  // Applies one request word to the bench state and returns the result word it must give.
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t r;
    int        lim;
    int        idx;
    r = '0;
    lim = usable_limit();
    idx = int'(w.block_index);
    case (w.kind)
      KIND_ALLOC: begin
        if (!mounted) begin
          r.status = ST_DISABLED;
          off_count++;
        end else begin
          r.status = ST_NO_FREE;
          // First fit from the first unreserved block.
          for (int i = int'(meta_blocks); i < lim; i++) begin
            if (!used_blocks[i]) begin
              used_blocks[i] = 1'b1;
              used_total = used_total + 1'b1;
              r.granted_block = i[BLK_W-1:0];
              r.status = ST_OK;
              granted_list.push_back(r.granted_block);
              break;
            end
          end
          if (r.status == ST_OK) grant_count++;
          else full_count++;
        end
      end
      KIND_FREE: begin
        if (!mounted) begin
          r.status = ST_DISABLED;
          off_count++;
        end else if (idx >= lim) begin
          r.status = ST_RANGE;
        end else if (idx < int'(meta_blocks)) begin
          r.status = ST_RESERVED;
        end else if (used_blocks[idx]) begin
          used_blocks[idx] = 1'b0;
          if (used_total != 0) used_total = used_total - 1'b1;
        end
      end
      KIND_QUERY: begin
        // Queries answer even while the store is not mounted.
        if (idx >= lim) r.is_used = 1'b0;
        else if (idx < int'(meta_blocks)) r.is_used = 1'b1;
        else r.is_used = used_blocks[idx];
      end
      default: begin
        // The unused kind changes nothing and reports only the free count.
      end
    endcase
    r.free_count = spare_blocks();
    return r;
  endfunction

  // Offers one request word, waits for it to be taken, then records what it must give.
  task automatic send_request(input kind_t kind, input logic [BLK_W-1:0] idx);
    in_word_t w;
    int       gap;
    w.kind = kind;
    w.block_index = idx;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    awaited_words.push_back(apply_request(w));
    kind_tally[kind]++;
    // Bursts of random length separated by random gaps.
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic halt_input();
    in_valid <= 1'b0;
  endtask

  // Waits until every owed result word has come back and the block has settled.
  task automatic wait_idle();
    halt_input();
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input cfg_idx_t idx, input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_ENABLED:  mounted = value[0];
      CFG_TOTAL:    dev_blocks = value;
      CFG_RESERVED: meta_blocks = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input bit en, input logic [CNT_W-1:0] total,
                            input logic [CNT_W-1:0] res);
    wait_idle();
    write_reg(CFG_ENABLED, {{(CNT_W-1){1'b0}}, en});
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_RESERVED, res);
    cfg_valid <= 1'b0;
  endtask

  // Random request, mostly aimed near the edges of the usable range.
  task automatic send_random_request();
    int               roll;
    int               lim;
    int               lo;
    int               hi;
    int               pick;
    logic [BLK_W-1:0] idx;
    roll = $urandom_range(0, 99);
    lim = usable_limit();
    lo = ((int'(meta_blocks) < lim) ? int'(meta_blocks) : lim) - 4;
    hi = ((int'(meta_blocks) > lim) ? int'(meta_blocks) : lim) + 4;
    if (lo < 0) lo = 0;
    if (lo > INDEX_SPACE - 1) lo = INDEX_SPACE - 1;
    if (hi > INDEX_SPACE - 1) hi = INDEX_SPACE - 1;
    if ($urandom_range(0, 9) < 7) idx = BLK_W'($urandom_range(lo, hi));
    else idx = BLK_W'($urandom());
    if (roll < 40) begin
      send_request(KIND_ALLOC, idx);
    end else if (roll < 65 && granted_list.size() != 0) begin
      // Well-formed free of a block handed out earlier.
      pick = $urandom_range(0, granted_list.size() - 1);
      idx = granted_list[pick];
      granted_list.delete(pick);
      send_request(KIND_FREE, idx);
    end else if (roll < 75) begin
      send_request(KIND_FREE, idx);
    end else if (roll < 96) begin
      send_request(KIND_QUERY, idx);
    end else begin
      send_request(KIND_NONE, idx);
    end
  endtask

  task automatic run_phase(input bit en, input int total, input int res, input int count,
                           input stall_mode_t mode, input int gaps);
    set_config(en, CNT_W'(total), CNT_W'(res));
    stall_mode = mode;
    gap_max = gaps;
    burst_left = 0;
    repeat (count) send_random_request();
  endtask

  // Out of reset the store is not mounted: allocate and free are refused, query still answers.
  task automatic test_unmounted_requests();
    stall_mode = STALL_NONE;
    gap_max = 0;
    send_request(KIND_ALLOC, 12'd0);
    send_request(KIND_FREE, 12'd100);
    send_request(KIND_QUERY, 12'd9);
    send_request(KIND_QUERY, 12'd10);
    send_request(KIND_NONE, 12'hFFF);
  endtask

  // Small device: first fit, full map, range and reserved refusals, double free.
  task automatic test_first_fit_and_free();
    set_config(1'b1, 13'd8, 13'd4);
    stall_mode = STALL_PATTERN;
    repeat (5) send_request(KIND_ALLOC, 12'd0);
    send_request(KIND_FREE, 12'd8);
    send_request(KIND_FREE, 12'hFFF);
    send_request(KIND_FREE, 12'd3);
    send_request(KIND_FREE, 12'd5);
    send_request(KIND_FREE, 12'd5);
    send_request(KIND_QUERY, 12'd5);
    send_request(KIND_QUERY, 12'd6);
    send_request(KIND_QUERY, 12'd2);
    send_request(KIND_ALLOC, 12'hFFF);
  endtask

  // Total above the index space with one usable block at the top; free count saturates.
  task automatic test_top_of_index_space();
    set_config(1'b1, 13'h1FFF, 13'd4095);
    stall_mode = STALL_RANDOM;
    gap_max = 3;
    send_request(KIND_ALLOC, 12'd0);
    send_request(KIND_QUERY, 12'hFFF);
    send_request(KIND_ALLOC, 12'd0);
    send_request(KIND_FREE, 12'hFFF);
    send_request(KIND_QUERY, 12'hFFF);
  endtask

  // Zero-sized device, with reservations at and beyond the total.
  task automatic test_degenerate_sizes();
    set_config(1'b1, 13'd0, 13'h1FFF);
    gap_max = 0;
    send_request(KIND_ALLOC, 12'd0);
    send_request(KIND_QUERY, 12'd0);
    send_request(KIND_FREE, 12'd0);
    set_config(1'b1, 13'd0, 13'd0);
    send_request(KIND_ALLOC, 12'd0);
  endtask

  // Random traffic across a spread of register settings and pacing.
  task automatic test_random_traffic();
    run_phase(1'b1, 4096, 10, 100, STALL_NONE, 0);
    run_phase(1'b1, 48, 0, 100, STALL_RANDOM, 6);
    run_phase(1'b1, 300, 200, 80, STALL_PATTERN, 4);
    run_phase(1'b0, 300, 200, 40, STALL_RANDOM, 8);
    run_phase(1'b1, 8191, 4000, 80, STALL_PATTERN, 2);
    run_phase(1'b1, 130, 140, 30, STALL_RANDOM, 5);
    run_phase(1'b1, 4096, 0, 100, STALL_RANDOM, 3);
    run_phase(1'b1, 64, 63, 40, STALL_NONE, 0);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_hold();
    set_config(1'b1, 13'd256, 13'd16);
    stall_mode = STALL_NONE;
    gap_max = 0;
    hold_token++;
    repeat (40) send_random_request();
  endtask

  // Receiver stall: long hold when asked, otherwise random or a fixed pattern.
  always @(posedge clk) begin : stall_gen
    int hold_seen;
    int hold_left;
    int stall_phase;
    bit [10:0] stall_pat;
    stall_pat = 11'b01100011101;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: out_stall <= stall_pat[stall_phase % 11];
        default:       out_stall <= 1'b0;
      endcase
    end
    stall_phase++;
  end

  // Each result word taken is compared with the oldest one owed.
  always @(posedge clk) begin : check_result
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        $error("result word with nothing outstanding: %p", out_data);
        error_count++;
      end else begin
        want = awaited_words.pop_front();
        checked_count++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.granted_block !== want.granted_block) begin
          $error("granted_block: expected %0d, got %0d", want.granted_block,
                 out_data.granted_block);
          error_count++;
        end
        if (out_data.is_used !== want.is_used) begin
          $error("is_used: expected %0d, got %0d", want.is_used, out_data.is_used);
          error_count++;
        end
        if (out_data.free_count !== want.free_count) begin
          $error("free_count: expected %0d, got %0d", want.free_count, out_data.free_count);
          error_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run limit of %0d cycles reached.", LIMIT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main
    int drain;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_unmounted_requests();
    test_first_fit_and_free();
    test_top_of_index_space();
    test_degenerate_sizes();
    test_random_traffic();
    test_output_hold();

    // Drain whatever is still owed, then watch for stray words.
    halt_input();
    drain = 0;
    while (awaited_words.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (awaited_words.size() != 0) begin
      $error("%0d result words never arrived", awaited_words.size());
      error_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d allocate, %0d free, %0d query, %0d unused kind); %0d checked.",
             kind_tally[0] + kind_tally[1] + kind_tally[2] + kind_tally[3], kind_tally[0],
             kind_tally[1], kind_tally[2], kind_tally[3], checked_count);
    $display("Blocks granted: %0d; refused on a full map: %0d; refused while unmounted: %0d.",
             grant_count, full_count, off_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bba_pkg.sv
src/bitmap_block_allocator.sv
tb/sv/bitmap_block_allocator_test.sv
